// ===== rtl/multi_channel_pwm_generator_macros.svh =====
// assertion macros for the multi-channel pwm generator
// no dependencies; included by the top level, which supplies clk and rst
`ifndef MULTI_CHANNEL_PWM_GENERATOR_MACROS_SVH
`define MULTI_CHANNEL_PWM_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define MCPWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcpwm assertion failed");

// next-cycle implication, checked outside reset
`define MCPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcpwm assertion failed");

`endif

// ===== rtl/mcpwm_pkg.sv =====
// shared types, constants and the pin map of the multi-channel pwm generator
// no dependencies; used by all rtl modules through scoped names
package mcpwm_pkg;

  localparam int CHANNELS   = 8;
  localparam int WIDTH_W    = 17;
  localparam int CHAN_W     = 4;
  localparam int PINS_W     = 12;
  localparam int PIN_IDX_W  = 4;

  localparam logic [WIDTH_W-1:0] PERIOD_RESET = 17'd93712;

  // pin bit for channels 1..8
  localparam logic [PIN_IDX_W-1:0] PIN_MAP [8] = '{
    4'd8, 4'd10, 4'd9, 4'd11, 4'd6, 4'd7, 4'd4, 4'd5
  };

  typedef enum logic [0:0] {
    CMD_TICK      = 1'b0,
    CMD_SET_WIDTH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [CHAN_W-1:0]  channel;
    logic [WIDTH_W-1:0] width;
  } in_t;

  typedef struct packed {
    logic [PINS_W-1:0]  pins;
    logic [WIDTH_W-1:0] position;
  } out_t;

  // result of one accepted transaction, core to output buffer
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

// ===== rtl/mcpwm_core.sv =====
// period counter, width registers and pin compare of the pwm generator
// depends on mcpwm_pkg
module mcpwm_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mcpwm_pkg::WIDTH_W-1:0] cfg_data,
  input  logic                          item_fire,
  input  mcpwm_pkg::in_t                item,
  output mcpwm_pkg::res_t               res
);

  logic [mcpwm_pkg::WIDTH_W-1:0] period;
  logic [mcpwm_pkg::WIDTH_W-1:0] count;
  logic [mcpwm_pkg::WIDTH_W-1:0] count_next;
  logic [mcpwm_pkg::WIDTH_W-1:0] count_inc;
  logic [mcpwm_pkg::WIDTH_W-1:0] chan_width [mcpwm_pkg::CHANNELS];
  logic [mcpwm_pkg::PINS_W-1:0]  pins;
  logic                          is_tick;

  assign is_tick   = (item.command == mcpwm_pkg::CMD_TICK);
  // wraps at 17 bits, then to zero at the period
  assign count_inc  = count + mcpwm_pkg::WIDTH_W'(1);
  assign count_next = (count_inc >= period) ? '0 : count_inc;

  always_comb begin
    pins = '0;
    for (int i = 0; i < mcpwm_pkg::CHANNELS; i++) begin
      if (count_next < chan_width[i]) begin
        pins[mcpwm_pkg::PIN_MAP[i]] = 1'b1;
      end
    end
  end

  assign res.valid         = item_fire && is_tick;
  assign res.data.pins     = pins;
  assign res.data.position = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= mcpwm_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < mcpwm_pkg::CHANNELS; i++) begin
        chan_width[i] <= '0;
      end
    end else if (item_fire) begin
      if (is_tick) begin
        count <= count_next;
      end else begin
        // channel 0 writes all, 1..CHANNELS one, others nothing
        for (int i = 0; i < mcpwm_pkg::CHANNELS; i++) begin
          if (item.channel == '0 || item.channel == mcpwm_pkg::CHAN_W'(i + 1)) begin
            chan_width[i] <= item.width;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/mcpwm_outbuf.sv =====
// output register with one skid entry for the pwm result channel
// depends on mcpwm_pkg
module mcpwm_outbuf (
  input  logic            clk,
  input  logic            rst,
  input  mcpwm_pkg::res_t res,
  output logic            can_take,
  output logic            result_valid,
  input  logic            result_ready,
  output mcpwm_pkg::out_t result
);

  logic            skid_valid;
  mcpwm_pkg::out_t skid;
  logic            pop;

  assign can_take = !skid_valid;
  assign pop      = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || pop) begin
      if (skid_valid) begin
        result <= skid;
        result_valid <= 1'b1;
        if (res.valid) begin
          skid <= res.data;
        end else begin
          skid_valid <= 1'b0;
        end
      end else begin
        result       <= res.data;
        result_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid       <= res.data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== rtl/multi_channel_pwm_generator.sv =====
// top level of the eight-channel pwm generator with a shared period counter
// depends on mcpwm_pkg, mcpwm_core, mcpwm_outbuf and the macros header
//
// usage:
//   item channel (item_valid/item_ready, payload item): a tick transaction
//   advances the shared period counter and yields one result; a set-width
//   transaction loads channel 1..8, or all of them for channel 0, and
//   yields nothing. the new width shows from the next tick on.
//   result channel (result_valid/result_ready, payload result): pin word
//   with channels on bits 4..11 and the counter position after the tick.
//   cfg_we/cfg_data: loads the period register, no handshake.
// throughput: one transaction per cycle while item_ready is high, ticks and set-widths alike.
// result path: a tick's result comes out of the output register; counter
//   step, wrap compare and the eight width compares are all combinational
//   logic in front of that register.
// stall: while the receiver holds off, one more result parks in a skid
//   entry; item_ready drops only while that entry is occupied.
// reset: period back to 93712, counter and all widths to zero (pins low),
//   output and skid empty.
`include "multi_channel_pwm_generator_macros.svh"

module multi_channel_pwm_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mcpwm_pkg::WIDTH_W-1:0] cfg_data,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  mcpwm_pkg::in_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output mcpwm_pkg::out_t               result
);

  logic            item_fire;
  logic            tick_fire;
  mcpwm_pkg::res_t res;
  logic            can_take;

  // accept whenever the skid entry is free, so a single stalled result does not block
  assign item_ready = can_take;
  assign item_fire  = item_valid && item_ready;
  assign tick_fire  = item_fire && (item.command == mcpwm_pkg::CMD_TICK);

  // state and the combinational result logic
  mcpwm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .item_fire (item_fire),
    .item      (item),
    .res       (res)
  );

  // result register plus skid entry
  mcpwm_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .can_take     (can_take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // skid is only used when the output register is occupied
  `MCPWM_ASSERT_IMPL(a_skid_implies_out, !item_ready, result_valid)
  // an accepted tick always shows a result on the next cycle
  `MCPWM_ASSERT_NEXT(a_tick_gives_result, tick_fire, result_valid)
  // low pin bits carry no channel
  `MCPWM_ASSERT_IMPL(a_low_pins_zero, result_valid, result.pins[3:0] == 4'd0)

endmodule
